// File: src/hlrt_pkg.sv
// ----------------------------------------------------------------------------
// hlrt_pkg
// Shared types, codes and helper functions of the host link read transaction.
// ----------------------------------------------------------------------------
package hlrt_pkg;

  localparam int RecvBufBytes = 256;
  localparam int MaxWords     = 61;
  localparam int WAddrW       = $clog2(MaxWords);
  localparam int RxCntW       = 9;

  localparam logic [7:0] ChAt   = 8'h40;
  localparam logic [7:0] ChStar = 8'h2A;
  localparam logic [7:0] ChCr   = 8'd13;
  localparam logic [7:0] ChZero = 8'h30;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_WORD = 2'd1;
  localparam logic [1:0] KIND_STAT = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_PLC     = 3'd1;
  localparam logic [2:0] ST_BADTERM = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_TOOBIG  = 3'd4;
  localparam logic [2:0] ST_BADAREA = 3'd5;

  localparam logic [2:0] REG_STATION = 3'd0;
  localparam logic [2:0] REG_AREA    = 3'd1;
  localparam logic [2:0] REG_SADDR   = 3'd2;
  localparam logic [2:0] REG_WCOUNT  = 3'd3;
  localparam logic [2:0] REG_TBASE   = 3'd4;
  localparam logic [2:0] REG_TIMEOUT = 3'd5;

  // Controller to datapath commands.
  typedef struct packed {
    logic       start;      // latch run values, clear counters
    logic       byte_in;    // process one received byte
    logic       tick;       // advance tick counter
    logic       dig_load;   // load the digit shifter for the frame
    logic       dig_step;   // produce one more decimal digit
    logic       wrd_rd;     // issue a word store read
    logic       wrd_next;   // advance the word read index
  } hlrt_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic       area_bad;
    logic       too_big;
    logic       plc_err;
    logic       frame_done;
    logic       term_ok;
    logic       timed_out;
    logic       words_done;
  } hlrt_stat_t;

  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [3:0] r;
    r = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) r = c[3:0];
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      r = c[3:0] + 4'd9;
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
  endfunction

  function automatic logic [7:0] area_letter(input logic [3:0] a);
    logic [7:0] r;
    case (a)
      4'd0: r = 8'h52;
      4'd1: r = 8'h48;
      4'd2: r = 8'h4A;
      4'd3: r = 8'h4C;
      4'd4: r = 8'h44;
      4'd5: r = 8'h43;
      default: r = 8'h3F;
    endcase
    return r;
  endfunction

endpackage

// File: src/hlrt_ram.sv
// ----------------------------------------------------------------------------
// hlrt_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hlrt_ram #(
  parameter int Width = 16,
  parameter int Depth = 61
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// File: src/hlrt_datapath.sv
// ----------------------------------------------------------------------------
// hlrt_datapath
// Frame builder, response parser, word store and tick counter.
// ----------------------------------------------------------------------------
module hlrt_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  hlrt_pkg::hlrt_cmd_t cmd,
  input  logic [7:0]         rx_byte,
  input  logic [6:0]         station,
  input  logic [3:0]         area,
  input  logic [13:0]        start_address,
  input  logic [13:0]        word_count,
  input  logic [15:0]        target_base,
  input  logic [31:0]        timeout_ticks,
  input  logic [4:0]         frame_idx,
  output hlrt_pkg::hlrt_stat_t stat,
  output logic [7:0]         tx_byte,
  output logic [15:0]        word_addr,
  output logic [15:0]        word_value,
  output logic [7:0]         plc_code
);
  logic [hlrt_pkg::RxCntW:0] rx_count_r;
  logic [15:0]               resp_code_r;
  logic [15:0]               word_accum_r;
  logic [31:0]               tick_count_r;
  logic [13:0]               run_count_r;
  logic [15:0]               run_base_r;
  logic [hlrt_pkg::WAddrW:0] rd_idx_r;
  // Digit generation: 10 decimal digits (station 2, address 4, count 4).
  logic [13:0]               dval_r;
  logic [3:0]                dig_r [10];
  logic [3:0]                dpos_r;
  logic [7:0]                x_r;

  localparam int RxW = hlrt_pkg::RxCntW;

  logic [15:0] need;
  logic [15:0] need_run;
  logic [15:0] p;
  logic        in_words;
  logic        we;
  logic [hlrt_pkg::WAddrW-1:0] waddr;
  logic [15:0] acc_nxt;
  logic [7:0]  fb [17];
  logic [7:0]  xs;

  assign need     = 16'd11 + {word_count, 2'b00};
  assign need_run = 16'd11 + {run_count_r, 2'b00};
  assign p        = {{(16-RxW-1){1'b0}}, rx_count_r};
  assign in_words = (p >= 16'd7) && (p < 16'd7 + {run_count_r, 2'b00});
  assign acc_nxt  = {word_accum_r[11:0], hlrt_pkg::nibble(rx_byte)};
  assign we       = cmd.byte_in && in_words && (p[1:0] == 2'd2) &&
                    (((p - 16'd7) >> 2) < 16'(hlrt_pkg::MaxWords));
  assign waddr    = hlrt_pkg::WAddrW'((p - 16'd7) >> 2);

  hlrt_ram #(.Width(16), .Depth(hlrt_pkg::MaxWords)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (acc_nxt),
    .re    (cmd.wrd_rd),
    .raddr (rd_idx_r[hlrt_pkg::WAddrW-1:0]),
    .rdata (word_value)
  );

  // Frame bytes; digits are produced one per cycle by the digit sequencer.
  always_comb begin
    fb[0]  = hlrt_pkg::ChAt;
    fb[1]  = 8'h30 + {4'd0, dig_r[0]};
    fb[2]  = 8'h30 + {4'd0, dig_r[1]};
    fb[3]  = 8'h52;
    fb[4]  = hlrt_pkg::area_letter(area);
    for (int i = 0; i < 8; i++) fb[5+i] = 8'h30 + {4'd0, dig_r[2+i]};
    xs = 8'd0;
    for (int i = 0; i < 13; i++) xs = xs ^ fb[i];
    fb[13] = hlrt_pkg::hex_char(x_r[7:4]);
    fb[14] = hlrt_pkg::hex_char(x_r[3:0]);
    fb[15] = hlrt_pkg::ChStar;
    fb[16] = hlrt_pkg::ChCr;
    tx_byte = (frame_idx < 5'd17) ? fb[frame_idx] : 8'd0;
  end

  // Digit sequencer: dpos selects which number, dval holds remaining value.
  logic [13:0] dv;
  logic [3:0]  dslot;
  always_comb begin
    dv = dval_r;
    dslot = 4'd0;
    case (dpos_r)
      4'd0: dslot = 4'd1;  4'd1: dslot = 4'd0;
      4'd2: dslot = 4'd5;  4'd3: dslot = 4'd4;
      4'd4: dslot = 4'd3;  4'd5: dslot = 4'd2;
      4'd6: dslot = 4'd9;  4'd7: dslot = 4'd8;
      4'd8: dslot = 4'd7;  4'd9: dslot = 4'd6;
      default: dslot = 4'd0;
    endcase
  end

  logic [13:0] dq;
  logic [3:0]  dr;
  assign dq = 14'((28'(dv) * 28'd6554) >> 16);
  always_comb begin
    dr = 4'(dv - 14'(dq * 4'd10));
  end
  logic [13:0] dq_fix;
  logic [3:0]  dr_fix;
  always_comb begin
    dq_fix = dq;
    dr_fix = dr;
    if (dr >= 4'd10 || dv < 14'(dq * 4'd10)) begin
      dq_fix = dq - 14'd1;
      dr_fix = 4'(dv - 14'((dq - 14'd1) * 4'd10));
    end
  end

  // The eleventh step only captures the frame check; no digit is stored then.
  always_ff @(posedge clk) begin
    if (cmd.dig_load) begin
      dval_r <= {7'd0, station};
      dpos_r <= 4'd0;
      x_r    <= 8'd0;
    end else if (cmd.dig_step) begin
      if (dpos_r < 4'd10) dig_r[dslot] <= dr_fix;
      dpos_r <= dpos_r + 4'd1;
      case (dpos_r)
        4'd1: dval_r <= start_address;
        4'd5: dval_r <= word_count;
        default: dval_r <= dq_fix;
      endcase
      if (dpos_r == 4'd10) x_r <= xs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_count_r   <= '0;
      resp_code_r  <= '0;
      word_accum_r <= '0;
      tick_count_r <= '0;
      run_count_r  <= '0;
      run_base_r   <= '0;
      rd_idx_r     <= '0;
    end else begin
      if (cmd.start) begin
        rx_count_r   <= '0;
        resp_code_r  <= '0;
        word_accum_r <= '0;
        tick_count_r <= '0;
        run_count_r  <= word_count;
        run_base_r   <= target_base;
        rd_idx_r     <= '0;
      end
      if (cmd.byte_in) begin
        rx_count_r <= rx_count_r + 1'b1;
        if (p == 16'd5) resp_code_r[15:8] <= rx_byte;
        if (p == 16'd6) resp_code_r[7:0]  <= rx_byte;
        if (in_words) word_accum_r <= acc_nxt;
      end
      if (cmd.tick && tick_count_r != 32'hFFFF_FFFF) tick_count_r <= tick_count_r + 32'd1;
      if (cmd.wrd_next) rd_idx_r <= rd_idx_r + 1'b1;
    end
  end

  assign word_addr = run_base_r + 16'(rd_idx_r) - 16'd1;
  assign plc_code  = {hlrt_pkg::nibble(resp_code_r[15:8]),
                      hlrt_pkg::nibble(resp_code_r[7:0])};

  always_comb begin
    stat.area_bad   = area > 4'd5;
    stat.too_big    = (need > 16'(hlrt_pkg::RecvBufBytes)) ||
                      (word_count > 14'(hlrt_pkg::MaxWords));
    stat.plc_err    = (p == 16'd10) && (rx_byte == hlrt_pkg::ChCr) &&
                      (resp_code_r != 16'h3030);
    stat.frame_done = (p + 16'd1 == need_run);
    stat.term_ok    = rx_byte == hlrt_pkg::ChCr;
    stat.timed_out  = ((tick_count_r == 32'hFFFF_FFFF) ? tick_count_r
                       : tick_count_r + 32'd1) >= timeout_ticks;
    stat.words_done = (16'(rd_idx_r) >= {2'b00, run_count_r}) ||
                      (rd_idx_r >= (hlrt_pkg::WAddrW+1)'(hlrt_pkg::MaxWords));
  end
endmodule

// File: src/hlrt_ctrl.sv
// ----------------------------------------------------------------------------
// hlrt_ctrl
// Controller: sequences frame transmission, response parsing and output.
// ----------------------------------------------------------------------------
module hlrt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic [2:0]           out_status,
  output logic                 out_last,
  output logic                 sel_tx,
  output logic                 sel_word,
  output logic                 sel_code,
  output logic [4:0]           frame_idx,
  output hlrt_pkg::hlrt_cmd_t  cmd,
  input  hlrt_pkg::hlrt_stat_t stat
);
  typedef enum logic [2:0] {
    S_IDLE, S_DIGIT, S_FRAME, S_WRD_RD, S_WRD_OUT, S_STAT
  } state_t;

  state_t      state_r, state_nxt;
  logic        busy_r, busy_nxt;
  logic [4:0]  fidx_r, fidx_nxt;
  logic [3:0]  dcnt_r, dcnt_nxt;
  logic [2:0]  st_r, st_nxt;
  logic        post_r, post_nxt;   // status 4 follows the frame
  logic        acc;

  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_valid = (state_r == S_FRAME) || (state_r == S_WRD_OUT) ||
                     (state_r == S_STAT);
  assign out_kind  = (state_r == S_FRAME) ? hlrt_pkg::KIND_TX :
                     (state_r == S_WRD_OUT) ? hlrt_pkg::KIND_WORD : hlrt_pkg::KIND_STAT;
  assign out_status = (state_r == S_STAT) ? st_r : 3'd0;
  assign out_last  = (state_r == S_STAT) ||
                     ((state_r == S_FRAME) && fidx_r == 5'd16 && !post_r);
  assign sel_tx    = state_r == S_FRAME;
  assign sel_word  = state_r == S_WRD_OUT;
  assign sel_code  = (state_r == S_STAT) && (st_r == hlrt_pkg::ST_PLC);
  assign frame_idx = fidx_r;

  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    fidx_nxt  = fidx_r;
    dcnt_nxt  = dcnt_r;
    st_nxt    = st_r;
    post_nxt  = post_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_cmd)
            hlrt_pkg::CMD_START: begin
              busy_nxt = 1'b0;
              if (stat.area_bad) begin
                st_nxt = hlrt_pkg::ST_BADAREA;
                state_nxt = S_STAT;
              end else begin
                cmd.dig_load = 1'b1;
                dcnt_nxt = 4'd0;
                post_nxt = stat.too_big;
                if (!stat.too_big) begin
                  cmd.start = 1'b1;
                  busy_nxt = 1'b1;
                end
                state_nxt = S_DIGIT;
              end
            end
            hlrt_pkg::CMD_BYTE: begin
              if (busy_r) begin
                cmd.byte_in = 1'b1;
                if (stat.plc_err) begin
                  busy_nxt = 1'b0;
                  st_nxt = hlrt_pkg::ST_PLC;
                  state_nxt = S_STAT;
                end else if (stat.frame_done) begin
                  busy_nxt = 1'b0;
                  if (!stat.term_ok) begin
                    st_nxt = hlrt_pkg::ST_BADTERM;
                    state_nxt = S_STAT;
                  end else begin
                    st_nxt = hlrt_pkg::ST_OK;
                    state_nxt = S_WRD_RD;
                  end
                end
              end
            end
            hlrt_pkg::CMD_TICK: begin
              if (busy_r) begin
                cmd.tick = 1'b1;
                if (stat.timed_out) begin
                  busy_nxt = 1'b0;
                  st_nxt = hlrt_pkg::ST_TIMEOUT;
                  state_nxt = S_STAT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_DIGIT: begin
        cmd.dig_step = 1'b1;
        dcnt_nxt = dcnt_r + 4'd1;
        if (dcnt_r == 4'd10) begin
          fidx_nxt = 5'd0;
          state_nxt = S_FRAME;
        end
      end
      S_FRAME: begin
        if (out_ready) begin
          fidx_nxt = fidx_r + 5'd1;
          if (fidx_r == 5'd16) begin
            if (post_r) begin
              st_nxt = hlrt_pkg::ST_TOOBIG;
              state_nxt = S_STAT;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_WRD_RD: begin
        if (stat.words_done) begin
          state_nxt = S_STAT;
        end else begin
          cmd.wrd_rd = 1'b1;
          cmd.wrd_next = 1'b1;
          state_nxt = S_WRD_OUT;
        end
      end
      S_WRD_OUT: begin
        if (out_ready) state_nxt = S_WRD_RD;
      end
      S_STAT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      fidx_r  <= 5'd0;
      dcnt_r  <= 4'd0;
      st_r    <= 3'd0;
      post_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      fidx_r  <= fidx_nxt;
      dcnt_r  <= dcnt_nxt;
      st_r    <= st_nxt;
      post_r  <= post_nxt;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("input taken while working");
  a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FRAME) |-> (fidx_r <= 5'd16)) else $error("frame index overrun");
  a_stat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STAT && out_ready) |=> (state_r == S_IDLE))
    else $error("status not followed by idle");
  a_busy_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRD_OUT) |-> !busy_r) else $error("busy during word output");
endmodule

// File: src/host_link_read_transaction.sv
// ----------------------------------------------------------------------------
// host_link_read_transaction
// Host link read transaction: builds the read command and parses the reply.
// ----------------------------------------------------------------------------
// A start beat builds the frame (one decimal digit a cycle from a reciprocal
// multiply), then emits its 17 frame bytes one a cycle while the sink is
// ready, plus a status beat if the request is too big (a bad area sends only
// the status). The closing byte of a good reply then reads the word store
// one word at a time (registered RAM read, then output), followed by an OK
// status. Input is taken only while no result is pending, and each result
// stays until the sink takes it. The user is to make configuration writes
// only between runs, to take effect on the next start; the block does not
// enforce this. Word count and target base are latched at start.
module host_link_read_transaction (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic [15:0] out_word_addr,
  output logic [15:0] out_word_value,
  output logic [2:0]  out_status,
  output logic [7:0]  out_plc_code,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [6:0]  station_r;
  logic [3:0]  area_r;
  logic [13:0] saddr_r;
  logic [13:0] wcount_r;
  logic [15:0] tbase_r;
  logic [31:0] timeout_r;

  hlrt_pkg::hlrt_cmd_t  cmd;
  hlrt_pkg::hlrt_stat_t stat;
  logic        sel_tx, sel_word, sel_code;
  logic [4:0]  frame_idx;
  logic [7:0]  tx_b, code;
  logic [15:0] waddr, wval;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  // Register file; a write lands on the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= 7'd0;
      area_r    <= 4'd4;
      saddr_r   <= 14'd0;
      wcount_r  <= 14'd1;
      tbase_r   <= 16'd0;
      timeout_r <= 32'd1000;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        hlrt_pkg::REG_STATION: station_r <= pwdata[6:0];
        hlrt_pkg::REG_AREA:    area_r    <= pwdata[3:0];
        hlrt_pkg::REG_SADDR:   saddr_r   <= pwdata[13:0];
        hlrt_pkg::REG_WCOUNT:  wcount_r  <= pwdata[13:0];
        hlrt_pkg::REG_TBASE:   tbase_r   <= pwdata[15:0];
        hlrt_pkg::REG_TIMEOUT: timeout_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      hlrt_pkg::REG_STATION: prdata = {25'd0, station_r};
      hlrt_pkg::REG_AREA:    prdata = {28'd0, area_r};
      hlrt_pkg::REG_SADDR:   prdata = {18'd0, saddr_r};
      hlrt_pkg::REG_WCOUNT:  prdata = {18'd0, wcount_r};
      hlrt_pkg::REG_TBASE:   prdata = {16'd0, tbase_r};
      hlrt_pkg::REG_TIMEOUT: prdata = timeout_r;
      default:               prdata = 32'd0;
    endcase
  end

  // Station and numbers are reduced modulo 100 / 10000 in the digit sequencer
  // by taking only the low digits it produces.
  hlrt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .out_status (out_status),
    .out_last   (out_last),
    .sel_tx     (sel_tx),
    .sel_word   (sel_word),
    .sel_code   (sel_code),
    .frame_idx  (frame_idx),
    .cmd        (cmd),
    .stat       (stat)
  );

  hlrt_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .rx_byte       (in_rx_byte),
    .station       (station_r),
    .area          (area_r),
    .start_address (saddr_r),
    .word_count    (wcount_r),
    .target_base   (tbase_r),
    .timeout_ticks (timeout_r),
    .frame_idx     (frame_idx),
    .stat          (stat),
    .tx_byte       (tx_b),
    .word_addr     (waddr),
    .word_value    (wval),
    .plc_code      (code)
  );

  assign out_tx_byte    = sel_tx   ? tx_b  : 8'd0;
  assign out_word_addr  = sel_word ? waddr : 16'd0;
  assign out_word_value = sel_word ? wval  : 16'd0;
  assign out_plc_code   = sel_code ? code  : 8'd0;
endmodule
